/* rtl/recent_packet_duplicate_filter_core_defines.svh */
// assertion macros used by the filter back end rtl
`ifndef RECENT_PACKET_DUPLICATE_FILTER_CORE_DEFINES_SVH
`define RECENT_PACKET_DUPLICATE_FILTER_CORE_DEFINES_SVH
`ifndef SYNTH
`define RPDF_ASSERT_HOLDS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rpdf check failed");
`define RPDF_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpdf check failed");
`define RPDF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpdf check failed");
`else
`define RPDF_ASSERT_HOLDS(lbl, clk, rst, prop)
`define RPDF_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define RPDF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/rpdf_pkg.sv */
`default_nettype none
package rpdf_pkg;
  localparam int TABLE_DEPTH_DEF = 128;
  localparam int MAX_PACKET_BYTES_DEF = 256;
  localparam logic [7:0] CAPACITY_AT_RESET = 8'd100;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIGEST_W = 160;

  localparam logic [DIGEST_W-1:0] SHA1_INIT = {
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] SHA1_K0 = 32'h5A827999;
  localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
  localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
  localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;

  // one finished packet digest or a table clear, front to back
  typedef struct packed {
    logic                clear;
    logic [DIGEST_W-1:0] digest;
  } q_item_t;
endpackage
`default_nettype wire

/* rtl/rpdf_ram.sv */
`default_nettype none
module rpdf_ram #(
  parameter int WIDTH = 160,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/rpdf_front.sv */
`default_nettype none
module rpdf_front #(
  parameter int MAX_PACKET_BYTES = rpdf_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_mode,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output rpdf_pkg::q_item_t      q_item
);
  localparam int LW = $clog2(MAX_PACKET_BYTES + 1);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_COMP = 4'b0010,
    F_PAD  = 4'b0100,
    F_PUSH = 4'b1000
  } f_state_t;

  // what follows the running compression
  typedef enum logic [3:0] {
    NX_IDLE = 4'b0001,
    NX_PAD  = 4'b0010,
    NX_PAD2 = 4'b0100,
    NX_PUSH = 4'b1000
  } nx_t;

  f_state_t       state;
  nx_t            after;
  logic           push_clear;
  logic [159:0]   chain;
  logic [511:0]   blk_buf;
  logic [LW-1:0]  len;
  logic [31:0]    a, b, c, d, e;
  logic [31:0]    w [16];
  logic [6:0]     round;

  logic [5:0]     pos;
  logic           absorb;
  logic [511:0]   buf_wr;
  logic [31:0]    nbits;
  logic [511:0]   pad_first, pad_single, pad_len_blk;
  logic           pad_two;
  logic           ld_en;
  logic [511:0]   ld_blk;
  logic [159:0]   ld_chain;
  logic [31:0]    f, k, t, w_new;
  logic [159:0]   chain_sum;
  logic           accept;
  logic           last_round;

  function automatic logic [511:0] pad_block(input logic [511:0] src, input logic [5:0] p,
                                             input logic with_len, input logic [31:0] nb);
    logic [511:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (6'(i) < p) begin
        r[511-8*i -: 8] = src[511-8*i -: 8];
      end else if (6'(i) == p) begin
        r[511-8*i -: 8] = 8'h80;
      end
    end
    if (with_len) begin
      r[31:0] = nb;
    end
    return r;
  endfunction

  assign in_ready   = (state == F_IDLE);
  assign accept     = in_valid && in_ready;
  assign q_valid    = (state == F_PUSH);
  assign q_item     = '{clear: push_clear, digest: chain};
  assign last_round = (round == 7'd79);

  always_comb begin
    pos         = len[5:0];
    absorb      = (len < LW'(MAX_PACKET_BYTES));
    buf_wr      = blk_buf;
    buf_wr[511 - 8 * int'(pos) -: 8] = in_byte;
    nbits       = 32'({len, 3'b000});
    pad_two     = (pos >= 6'd56);
    pad_first   = pad_block(blk_buf, pos, 1'b0, nbits);
    pad_single  = pad_block(blk_buf, pos, 1'b1, nbits);
    pad_len_blk = {480'd0, nbits};
  end

  always_comb begin
    if (round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = rpdf_pkg::SHA1_K0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = rpdf_pkg::SHA1_K1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = rpdf_pkg::SHA1_K2;
    end else begin
      f = b ^ c ^ d;
      k = rpdf_pkg::SHA1_K3;
    end
    t = {a[26:0], a[31:27]} + f + e + k + w[0];
    w_new = w[13] ^ w[8] ^ w[2] ^ w[0];
    w_new = {w_new[30:0], w_new[31]};
    // fold in the working values as they stand after the final round
    chain_sum = {chain[159:128] + t, chain[127:96] + a, chain[95:64] + {b[1:0], b[31:2]},
                 chain[63:32] + c, chain[31:0] + d};
  end

  // start of a 64-byte compression
  always_comb begin
    ld_en    = 1'b0;
    ld_blk   = buf_wr;
    ld_chain = chain;
    case (state)
      F_IDLE: begin
        if (accept && !in_mode && absorb && pos == 6'd63) begin
          ld_en = 1'b1;
        end
      end
      F_PAD: begin
        ld_en  = 1'b1;
        ld_blk = pad_two ? pad_first : pad_single;
      end
      F_COMP: begin
        if (last_round && after == NX_PAD2) begin
          ld_en    = 1'b1;
          ld_blk   = pad_len_blk;
          ld_chain = chain_sum;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld_en) begin
      a     <= ld_chain[159:128];
      b     <= ld_chain[127:96];
      c     <= ld_chain[95:64];
      d     <= ld_chain[63:32];
      e     <= ld_chain[31:0];
      round <= '0;
      for (int i = 0; i < 16; i++) begin
        w[i] <= ld_blk[511-32*i -: 32];
      end
    end else if (state == F_COMP) begin
      a     <= t;
      b     <= a;
      c     <= {b[1:0], b[31:2]};
      d     <= c;
      e     <= d;
      round <= round + 7'd1;
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      after      <= NX_IDLE;
      push_clear <= 1'b0;
      chain      <= rpdf_pkg::SHA1_INIT;
      len        <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            push_clear <= in_mode;
            if (in_mode) begin
              state <= F_PUSH;
            end else begin
              if (absorb) begin
                blk_buf <= buf_wr;
                len     <= len + LW'(1);
              end
              if (ld_en) begin
                after <= in_last ? NX_PAD : NX_IDLE;
                state <= F_COMP;
              end else if (in_last) begin
                state <= F_PAD;
              end
            end
          end
        end
        F_PAD: begin
          after <= pad_two ? NX_PAD2 : NX_PUSH;
          state <= F_COMP;
        end
        F_COMP: begin
          if (last_round) begin
            chain <= chain_sum;
            case (after)
              NX_PAD:  state <= F_PAD;
              NX_PAD2: after <= NX_PUSH;
              NX_PUSH: state <= F_PUSH;
              default: state <= F_IDLE;
            endcase
          end
        end
        F_PUSH: begin
          if (q_ready) begin
            chain <= rpdf_pkg::SHA1_INIT;
            len   <= '0;
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/rpdf_queue.sv */
`default_nettype none
module rpdf_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rpdf_pkg::q_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rpdf_pkg::q_item_t      out_item
);
  localparam int QD   = rpdf_pkg::QUEUE_DEPTH;
  localparam int PW   = (QD > 1) ? $clog2(QD) : 1;
  localparam int CNTW = $clog2(QD + 1);

  rpdf_pkg::q_item_t mem [QD];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [CNTW-1:0]   fill;
  logic              push, pop;

  assign in_ready  = (fill != CNTW'(QD));
  assign out_valid = (fill != '0);
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QD - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QD - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNTW'(1);
      end else if (pop && !push) begin
        fill <= fill - CNTW'(1);
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/rpdf_back.sv */
`default_nettype none
`include "recent_packet_duplicate_filter_core_defines.svh"
module rpdf_back #(
  parameter int TABLE_DEPTH = rpdf_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [7:0]        cfg_data,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire rpdf_pkg::q_item_t q_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_is_new,
  output logic [7:0]             out_entries
);
  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > 8) ? CW + 1 : 9;

  typedef enum logic [5:0] {
    B_IDLE   = 6'b000001,
    B_SRD    = 6'b000010,
    B_SCMP   = 6'b000100,
    B_MRD    = 6'b001000,
    B_MWR    = 6'b010000,
    B_APPEND = 6'b100000
  } b_state_t;

  b_state_t       state;
  logic [7:0]     cap;
  logic [CW-1:0]  count;
  logic [CW-1:0]  p;
  logic [159:0]   dig;
  logic           is_new;
  logic           grow;
  logic [AW-1:0]  wa;

  logic [CW-1:0]   p_inc, p_inc2, count_dec, count_fin;
  logic [CMPW-1:0] cap_ext, cnt_ext, fin_ext;
  logic            full;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [159:0]    ram_wdata, ram_rdata;
  logic            pop;

  assign cfg_ready = 1'b1;
  assign q_ready   = (state == B_IDLE) && !out_valid;
  assign pop       = q_valid && q_ready;

  always_comb begin
    p_inc     = p + CW'(1);
    p_inc2    = p + CW'(2);
    count_dec = count - CW'(1);
    count_fin = grow ? count + CW'(1) : count;
    cnt_ext   = CMPW'(count);
    fin_ext   = CMPW'(count_fin);
    // capacity zero acts as one, above the table depth it saturates
    if (cap == 8'd0) begin
      cap_ext = CMPW'(1);
    end else if (CMPW'(cap) > CMPW'(TABLE_DEPTH)) begin
      cap_ext = CMPW'(TABLE_DEPTH);
    end else begin
      cap_ext = CMPW'(cap);
    end
    full = (cnt_ext >= cap_ext);
  end

  // table rows kept oldest first, so a move is a shift down by one row
  always_comb begin
    ram_raddr = (state == B_MRD) ? p_inc[AW-1:0] : p[AW-1:0];
    ram_we    = (state == B_MWR) || (state == B_APPEND);
    ram_waddr = (state == B_MWR) ? p[AW-1:0] : wa;
    ram_wdata = (state == B_MWR) ? ram_rdata : dig;
  end

  rpdf_ram #(
    .WIDTH(160),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cap       <= rpdf_pkg::CAPACITY_AT_RESET;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop) begin
            if (q_item.clear) begin
              count <= '0;
            end else begin
              dig    <= q_item.digest;
              p      <= '0;
              is_new <= 1'b1;
              grow   <= 1'b1;
              if (count == '0) begin
                wa    <= '0;
                state <= B_APPEND;
              end else begin
                state <= B_SRD;
              end
            end
          end
        end
        B_SRD: state <= B_SCMP;
        B_SCMP: begin
          if (ram_rdata == dig) begin
            is_new <= 1'b0;
            grow   <= 1'b0;
            wa     <= count_dec[AW-1:0];
            state  <= (p_inc < count) ? B_MRD : B_APPEND;
          end else if (p_inc == count) begin
            is_new <= 1'b1;
            if (full) begin
              // evict the oldest row, then add at the newest place
              grow  <= 1'b0;
              p     <= '0;
              wa    <= count_dec[AW-1:0];
              state <= (count > CW'(1)) ? B_MRD : B_APPEND;
            end else begin
              grow  <= 1'b1;
              wa    <= count[AW-1:0];
              state <= B_APPEND;
            end
          end else begin
            p     <= p_inc;
            state <= B_SRD;
          end
        end
        B_MRD: state <= B_MWR;
        B_MWR: begin
          p     <= p_inc;
          state <= (p_inc2 < count) ? B_MRD : B_APPEND;
        end
        B_APPEND: begin
          count       <= count_fin;
          out_valid   <= 1'b1;
          out_is_new  <= is_new;
          out_entries <= fin_ext[7:0];
          state       <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `RPDF_ASSERT_HOLDS(a_count_bound, clk, rst, cnt_ext <= CMPW'(TABLE_DEPTH))
  `RPDF_ASSERT_IMPLIES(a_scan_in_range, clk, rst, state == B_SCMP, p < count)
  `RPDF_ASSERT_NEXT(a_clear_empties, clk, rst, pop && q_item.clear, count == '0)
endmodule
`default_nettype wire

/* rtl/recent_packet_duplicate_filter_core.sv */
// input: bytes are taken while idle; each 64th hashed byte starts 80 sha-1 rounds that hold the input
// packet end: one or two padded blocks of sha-1 rounds, then a search of the digest table row by row
// and a shift down of the rows behind a match or an evicted row; the next packet may hash meanwhile
// a clear item holds the input until it is queued and gives no result
// reset: synchronous, active high; table empty, capacity 100, no clearing pass
`default_nettype none
module recent_packet_duplicate_filter_core #(
  parameter int TABLE_DEPTH      = rpdf_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_PACKET_BYTES = rpdf_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // data_byte
  input  wire logic       s_axis_tlast,
  input  wire logic       s_axis_tuser,   // mode
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // entries_held
  output logic            m_axis_tuser,   // is_new
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);
  rpdf_pkg::q_item_t fq_item, qb_item;
  logic              fq_valid, fq_ready, qb_valid, qb_ready;

  rpdf_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_mode (s_axis_tuser),
    .in_byte (s_axis_tdata),
    .in_last (s_axis_tlast),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_item  (fq_item)
  );

  rpdf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fq_valid),
    .in_ready (fq_ready),
    .in_item  (fq_item),
    .out_valid(qb_valid),
    .out_ready(qb_ready),
    .out_item (qb_item)
  );

  rpdf_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_item     (qb_item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_is_new (m_axis_tuser),
    .out_entries(m_axis_tdata)
  );
endmodule
`default_nettype wire
